// File: rtl/wtss_pkg.sv
// Shared types and constants of the weekly time switch scheduler.
package wtss_pkg;

    localparam int DAY_W  = 3;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int ID_W   = 8;

    // Wrap points of the clock counters
    localparam logic [MIN_W-1:0]  MIN_WRAP  = 6'd60;
    localparam logic [HOUR_W-1:0] HOUR_WRAP = 5'd24;
    localparam logic [DAY_W-1:0]  DAY_LAST  = 3'd6;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_APPEND = 2'd2,
        ACT_SET    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_REPORT = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_FULL   = 2'd2
    } kind_t;

    // One switching entry; also carries the clock value of a set command
    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [ID_W-1:0]   id;
        logic              on;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        action_t action;
        entry_t  entry;
    } cmd_t;

    // Queue head as seen by the execution side
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

// File: rtl/wtss_if.sv
// Request and response channel interfaces of the scheduler.
interface wtss_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [wtss_pkg::DAY_W-1:0]   weekday;
    logic [wtss_pkg::HOUR_W-1:0]  hour;
    logic [wtss_pkg::MIN_W-1:0]   minute;
    logic [wtss_pkg::ID_W-1:0]    entry_id;
    logic                         entry_on;

    modport source (
        output valid, action, weekday, hour, minute, entry_id, entry_on,
        input  ready
    );
    modport sink (
        input  valid, action, weekday, hour, minute, entry_id, entry_on,
        output ready
    );
endinterface

interface wtss_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [wtss_pkg::DAY_W-1:0]   clock_weekday;
    logic [wtss_pkg::HOUR_W-1:0]  clock_hour;
    logic [wtss_pkg::MIN_W-1:0]   clock_minute;
    logic [wtss_pkg::ID_W-1:0]    cmd_id;
    logic                         cmd_on;
    logic                         last;

    modport source (
        output valid, kind, clock_weekday, clock_hour, clock_minute, cmd_id, cmd_on, last,
        input  ready
    );
    modport sink (
        input  valid, kind, clock_weekday, clock_hour, clock_minute, cmd_id, cmd_on, last,
        output ready
    );
endinterface

// File: rtl/wtss_ram.sv
// Generic single-port-write, registered-read RAM.
module wtss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word; the read word is registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/wtss_front.sv
// Request intake: decode each beat into a command and hold it in a short queue.
module wtss_front (
    input  logic                clk,
    input  logic                rst_n,
    wtss_req_if.sink            req,
    output wtss_pkg::cmd_head_t head,
    input  logic                pop
);

    localparam int QDEPTH = 2;

    wtss_pkg::cmd_t q_reg [QDEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push;
    logic           do_pop;
    wtss_pkg::cmd_t cmd_in;

    // Classify the incoming beat
    always_comb
    begin
        cmd_in.action       = wtss_pkg::action_t'(req.action);
        cmd_in.entry.day    = req.weekday;
        cmd_in.entry.hour   = req.hour;
        cmd_in.entry.minute = req.minute;
        cmd_in.entry.id     = req.entry_id;
        cmd_in.entry.on     = req.entry_on;
    end

    assign req.ready = (fill_reg != 2'(QDEPTH));
    assign push      = req.valid && req.ready;
    assign do_pop    = pop && (fill_reg != 2'd0);

    // Advance queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the decoded command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (fill_reg != 2'd0);
    assign head.cmd   = q_reg[rd_ptr_reg];

endmodule

// File: rtl/wtss_back.sv
// Command execution: clock counters, entry table and the match scan.
module wtss_back #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_MATCHES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wtss_pkg::cmd_head_t head,
    output logic                pop,
    wtss_rsp_if.source          rsp
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int MW = $clog2(MAX_MATCHES + 1);
    localparam logic [CW-1:0] FULL_COUNT  = CW'(MAX_ENTRIES);
    localparam logic [MW-1:0] MATCH_LIMIT = MW'(MAX_MATCHES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    logic [wtss_pkg::MIN_W-1:0]     min_reg, min_next;
    logic [wtss_pkg::HOUR_W-1:0]    hour_reg, hour_next;
    logic [wtss_pkg::DAY_W-1:0]     day_reg, day_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  ptr_reg, ptr_next;
    logic [MW-1:0]                  mcnt_reg, mcnt_next;

    // Result held back until the scan shows whether it is the last one
    wtss_pkg::kind_t                pend_kind_reg, pend_kind_next;
    logic [wtss_pkg::ID_W-1:0]      pend_id_reg, pend_id_next;
    logic                           pend_on_reg, pend_on_next;

    logic                           out_valid_reg, out_valid_next;
    wtss_pkg::kind_t                out_kind_reg, out_kind_next;
    logic [wtss_pkg::DAY_W-1:0]     out_day_reg;
    logic [wtss_pkg::HOUR_W-1:0]    out_hour_reg;
    logic [wtss_pkg::MIN_W-1:0]     out_min_reg;
    logic [wtss_pkg::ID_W-1:0]      out_id_reg, out_id_next;
    logic                           out_on_reg, out_on_next;
    logic                           out_last_reg, out_last_next;
    logic                           load_out;

    logic                           wr_en;
    logic [AW-1:0]                  rd_addr;
    logic [wtss_pkg::ENTRY_W-1:0]   rd_data;
    wtss_pkg::entry_t               rd_entry;
    logic [CW-1:0]                  ptr_inc;

    logic [wtss_pkg::MIN_W-1:0]     min_inc;
    logic [wtss_pkg::HOUR_W-1:0]    hour_inc;
    logic [wtss_pkg::MIN_W-1:0]     tick_min;
    logic [wtss_pkg::HOUR_W-1:0]    tick_hour;
    logic [wtss_pkg::DAY_W-1:0]     tick_day;

    logic                           out_free;
    logic                           hit;
    logic                           scan_done;

    wtss_ram #(
        .WIDTH (wtss_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (head.cmd.entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = wtss_pkg::entry_t'(rd_data);
    assign ptr_inc  = ptr_reg + 1'b1;

    // Advance the clock by one minute with carries
    always_comb
    begin
        min_inc   = min_reg + 1'b1;
        hour_inc  = hour_reg + 1'b1;
        tick_min  = min_inc;
        tick_hour = hour_reg;
        tick_day  = day_reg;
        if (min_inc >= wtss_pkg::MIN_WRAP)
        begin
            tick_min  = '0;
            tick_hour = hour_inc;
            if (hour_inc >= wtss_pkg::HOUR_WRAP)
            begin
                tick_hour = '0;
                tick_day  = (day_reg >= wtss_pkg::DAY_LAST) ? '0 : day_reg + 1'b1;
            end
        end
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign hit       = (rd_entry.day == day_reg) && (rd_entry.hour == hour_reg)
                    && (rd_entry.minute == min_reg);
    assign scan_done = (ptr_reg == count_reg) || (mcnt_reg == MATCH_LIMIT);

    // Execute the head command or step the scan
    always_comb
    begin
        state_next     = state_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        day_next       = day_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        mcnt_next      = mcnt_reg;
        pend_kind_next = pend_kind_reg;
        pend_id_next   = pend_id_reg;
        pend_on_next   = pend_on_reg;
        load_out       = 1'b0;
        out_kind_next  = pend_kind_reg;
        out_id_next    = pend_id_reg;
        out_on_next    = pend_on_reg;
        out_last_next  = 1'b0;
        pop            = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = ptr_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = '0;
                if (head.valid)
                begin
                    case (head.cmd.action)
                        wtss_pkg::ACT_TICK:
                        begin
                            min_next       = tick_min;
                            hour_next      = tick_hour;
                            day_next       = tick_day;
                            pend_kind_next = wtss_pkg::KIND_REPORT;
                            pend_id_next   = '0;
                            pend_on_next   = 1'b0;
                            ptr_next       = '0;
                            mcnt_next      = '0;
                            state_next     = ST_SCAN;
                            pop            = 1'b1;
                        end
                        wtss_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            pop        = 1'b1;
                        end
                        wtss_pkg::ACT_APPEND:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                if (out_free)
                                begin
                                    load_out      = 1'b1;
                                    out_kind_next = wtss_pkg::KIND_FULL;
                                    out_id_next   = '0;
                                    out_on_next   = 1'b0;
                                    out_last_next = 1'b1;
                                    pop           = 1'b1;
                                end
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                pop        = 1'b1;
                            end
                        end
                        wtss_pkg::ACT_SET:
                        begin
                            day_next  = head.cmd.entry.day;
                            hour_next = head.cmd.entry.hour;
                            min_next  = head.cmd.entry.minute;
                            pop       = 1'b1;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    // Release the held result as the final beat
                    if (out_free)
                    begin
                        load_out      = 1'b1;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (hit)
                begin
                    // Hand on the held result, hold the new match
                    if (out_free)
                    begin
                        load_out       = 1'b1;
                        pend_kind_next = wtss_pkg::KIND_CMD;
                        pend_id_next   = rd_entry.id;
                        pend_on_next   = rd_entry.on;
                        mcnt_next      = mcnt_reg + 1'b1;
                        ptr_next       = ptr_inc;
                        rd_addr        = ptr_inc[AW-1:0];
                    end
                end
                else
                begin
                    ptr_next = ptr_inc;
                    rd_addr  = ptr_inc[AW-1:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= '0;
            hour_reg      <= '0;
            day_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture pending and output payloads
    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        pend_on_reg   <= pend_on_next;
        if (load_out)
        begin
            out_kind_reg <= out_kind_next;
            out_day_reg  <= day_reg;
            out_hour_reg <= hour_reg;
            out_min_reg  <= min_reg;
            out_id_reg   <= out_id_next;
            out_on_reg   <= out_on_next;
            out_last_reg <= out_last_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.clock_weekday = out_day_reg;
    assign rsp.clock_hour    = out_hour_reg;
    assign rsp.clock_minute  = out_min_reg;
    assign rsp.cmd_id        = out_id_reg;
    assign rsp.cmd_on        = out_on_reg;
    assign rsp.last          = out_last_reg;

endmodule

// File: rtl/weekly_time_switch_scheduler_top.sv
// Top level of the weekly time switch scheduler.
//
//  channel | dir | beat contents                                        | handshake
//  --------+-----+------------------------------------------------------+-------------
//  req     | in  | action, weekday, hour, minute, entry_id, entry_on    | valid/ready
//  rsp     | out | kind, clock_weekday/hour/minute, cmd_id, cmd_on, last | valid/ready
//
// A tick makes the execution side scan the table, one read per entry through the
// registered RAM port, up to the last entry or the match limit, then give the
// final beat; a matching entry waits while the sink stalls. Clear, append and
// set need no scan. A two-deep command queue sits in front of the execution side.
// Reset clears the clock, the entry count and all handshake state; the table
// contents are not cleared.
module weekly_time_switch_scheduler_top #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_MATCHES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    wtss_req_if.sink   req,
    wtss_rsp_if.source rsp
);

    wtss_pkg::cmd_head_t head;
    logic                pop;

    wtss_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    wtss_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

// File: rtl/wtss_checker.sv
// Port-level assertions of the scheduler and their bind to the top level.
module wtss_checker #(
    parameter int MAX_MATCHES = 8
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [1:0]                  kind,
    input logic [wtss_pkg::DAY_W-1:0]  clock_weekday,
    input logic [wtss_pkg::HOUR_W-1:0] clock_hour,
    input logic [wtss_pkg::MIN_W-1:0]  clock_minute,
    input logic [wtss_pkg::ID_W-1:0]   cmd_id,
    input logic                        cmd_on,
    input logic                        last
);

    localparam int MW = $clog2(MAX_MATCHES + 1);
    localparam logic [MW-1:0] MATCH_LIMIT = MW'(MAX_MATCHES);

    logic          open_reg;
    logic [MW-1:0] cmd_cnt_reg;
    logic          beat;
    logic          is_cmd;

    assign beat   = rsp_valid && rsp_ready;
    assign is_cmd = (kind == wtss_pkg::KIND_CMD);

    // Track an unfinished tick sequence and its command count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            cmd_cnt_reg <= '0;
        end
        else if (beat)
        begin
            if (last)
            begin
                open_reg    <= 1'b0;
                cmd_cnt_reg <= '0;
            end
            else
            begin
                open_reg <= 1'b1;
                if (is_cmd)
                begin
                    cmd_cnt_reg <= cmd_cnt_reg + 1'b1;
                end
            end
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({kind, clock_weekday, clock_hour, clock_minute, cmd_id, cmd_on, last}))
        else $error("response beat changed while stalled");

    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (kind == wtss_pkg::KIND_FULL) |-> last)
        else $error("table-full beat not marked last");

    a_cont_is_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && open_reg |-> is_cmd)
        else $error("non-command beat inside a tick sequence");

    a_cmd_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !open_reg |-> !is_cmd)
        else $error("command beat without a preceding clock report");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_cmd |-> (cmd_cnt_reg < MATCH_LIMIT))
        else $error("more command beats than the match limit");

endmodule

bind weekly_time_switch_scheduler_top wtss_checker #(
    .MAX_MATCHES (MAX_MATCHES)
) u_wtss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .kind          (rsp.kind),
    .clock_weekday (rsp.clock_weekday),
    .clock_hour    (rsp.clock_hour),
    .clock_minute  (rsp.clock_minute),
    .cmd_id        (rsp.cmd_id),
    .cmd_on        (rsp.cmd_on),
    .last          (rsp.last)
);

// File: sim/weekly_time_switch_scheduler_top_test.sv
// Self-checking testbench of the weekly time switch scheduler top level.
`timescale 1ns / 100ps

module weekly_time_switch_scheduler_top_test;

    localparam int MAX_ENTRIES  = 64;
    localparam int MAX_MATCHES  = 8;
    localparam int PHASE_BEATS  = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_ENTRIES + 40;
    localparam int RUN_LIMIT_NS = 5_000_000;

    // Idling per phase: none, sender only, receiver only, both
    localparam int unsigned IDLE_PCT  [4] = '{0, 47, 0, 36};
    localparam int unsigned STALL_PCT [4] = '{0, 0, 47, 36};

    typedef struct packed {
        logic [wtss_pkg::DAY_W-1:0]  day;
        logic [wtss_pkg::HOUR_W-1:0] hour;
        logic [wtss_pkg::MIN_W-1:0]  minute;
    } clock_t;

    typedef struct packed {
        wtss_pkg::kind_t             kind;
        logic [wtss_pkg::DAY_W-1:0]  day;
        logic [wtss_pkg::HOUR_W-1:0] hour;
        logic [wtss_pkg::MIN_W-1:0]  minute;
        logic [wtss_pkg::ID_W-1:0]   id;
        logic                        on;
        logic                        last;
    } rsp_beat_t;

    // Tracks the scheduler state and the response beats still due
    class switch_scoreboard;
        clock_t            now;
        wtss_pkg::entry_t  sched [MAX_ENTRIES];
        int unsigned       sched_count;
        rsp_beat_t         due_beats [$];
        int unsigned       error_count;

        function new();
            now         = '0;
            sched_count = 0;
            error_count = 0;
        endfunction

        // Advance one minute, wrapping at 60, 24 and 7 at the counter widths
        static function clock_t next_minute(clock_t c);
            clock_t n;
            n        = c;
            n.minute = c.minute + 1'b1;
            if (n.minute >= wtss_pkg::MIN_WRAP)
            begin
                n.minute = '0;
                n.hour   = c.hour + 1'b1;
                if (n.hour >= wtss_pkg::HOUR_WRAP)
                begin
                    n.hour = '0;
                    n.day  = (c.day >= wtss_pkg::DAY_LAST) ? '0 : c.day + 1'b1;
                end
            end
            return n;
        endfunction

        function void push_beat(wtss_pkg::kind_t k, logic [wtss_pkg::ID_W-1:0] id,
                                logic on, logic last);
            rsp_beat_t b;
            b.kind    = k;
            b.day     = now.day;
            b.hour    = now.hour;
            b.minute  = now.minute;
            b.id      = id;
            b.on      = on;
            b.last    = last;
            due_beats = {due_beats, b};
        endfunction

        // Note an accepted request beat and queue the response beats it causes
        function void take_request(wtss_pkg::action_t act, wtss_pkg::entry_t e);
            wtss_pkg::entry_t hits [MAX_MATCHES];
            int               n_hits;
            n_hits = 0;
            case (act)
                wtss_pkg::ACT_TICK:
                begin
                    now = next_minute(now);
                    for (int i = 0; i < sched_count; i++)
                    begin
                        if (n_hits >= MAX_MATCHES)
                            break;
                        if (sched[i].day == now.day && sched[i].hour == now.hour &&
                            sched[i].minute == now.minute)
                        begin
                            hits[n_hits] = sched[i];
                            n_hits++;
                        end
                    end
                    push_beat(wtss_pkg::KIND_REPORT, '0, 1'b0, n_hits == 0);
                    for (int k = 0; k < n_hits; k++)
                        push_beat(wtss_pkg::KIND_CMD, hits[k].id, hits[k].on, k == n_hits - 1);
                end
                wtss_pkg::ACT_CLEAR:
                begin
                    sched_count = 0;
                end
                wtss_pkg::ACT_APPEND:
                begin
                    if (sched_count >= MAX_ENTRIES)
                    begin
                        push_beat(wtss_pkg::KIND_FULL, '0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        sched[sched_count] = e;
                        sched_count++;
                    end
                end
                default:
                begin
                    now.day    = e.day;
                    now.hour   = e.hour;
                    now.minute = e.minute;
                end
            endcase
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                error_count++;
            end
        endfunction

        // Check one accepted response beat against the oldest one due
        function void check_response(rsp_beat_t got);
            rsp_beat_t want;
            if (due_beats.size() == 0)
            begin
                $error("unexpected response beat: kind %0d, cmd_id %0d", got.kind, got.id);
                error_count++;
                return;
            end
            want = due_beats.pop_front();
            compare("kind", 8'(want.kind), 8'(got.kind));
            compare("clock_weekday", 8'(want.day), 8'(got.day));
            compare("clock_hour", 8'(want.hour), 8'(got.hour));
            compare("clock_minute", 8'(want.minute), 8'(got.minute));
            compare("cmd_id", want.id, got.id);
            compare("cmd_on", 8'(want.on), 8'(got.on));
            compare("last", 8'(want.last), 8'(got.last));
        endfunction

        function int unsigned pending();
            return due_beats.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    wtss_req_if req_ch ();
    wtss_rsp_if rsp_ch ();

    switch_scoreboard schedule_sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned beats_sent    = 0;
    logic        hold_go       = 1'b0;
    logic        rsp_hold      = 1'b0;

    weekly_time_switch_scheduler_top #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_MATCHES (MAX_MATCHES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("weekly_time_switch_scheduler_top_test: done, errors");
        $finish;
    end

    // Hold off the response side for a long stretch once asked to
    initial
    begin : rsp_hold_ctl
        wait (hold_go);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Accept response beats, check them, and pick the next ready
    initial
    begin : rsp_side
        rsp_beat_t got;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.kind   = wtss_pkg::kind_t'(rsp_ch.kind);
                got.day    = rsp_ch.clock_weekday;
                got.hour   = rsp_ch.clock_hour;
                got.minute = rsp_ch.clock_minute;
                got.id     = rsp_ch.cmd_id;
                got.on     = rsp_ch.cmd_on;
                got.last   = rsp_ch.last;
                schedule_sb.check_response(got);
            end
            rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic wtss_pkg::entry_t make_entry(logic [wtss_pkg::DAY_W-1:0] d,
                                                    logic [wtss_pkg::HOUR_W-1:0] h,
                                                    logic [wtss_pkg::MIN_W-1:0] m,
                                                    logic [wtss_pkg::ID_W-1:0] id,
                                                    logic on);
        wtss_pkg::entry_t e;
        e.day    = d;
        e.hour   = h;
        e.minute = m;
        e.id     = id;
        e.on     = on;
        return e;
    endfunction

    // Random entry, now and then with out-of-range time fields
    function automatic wtss_pkg::entry_t rand_entry();
        wtss_pkg::entry_t e;
        e.day    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(0, 6));
        e.hour   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 23));
        e.minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 59));
        e.id     = 8'($urandom_range(0, 255));
        e.on     = 1'($urandom_range(0, 1));
        return e;
    endfunction

    // Offer one request beat and hold it until accepted
    task automatic send_beat(wtss_pkg::action_t act, wtss_pkg::entry_t e);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.weekday  <= e.day;
        req_ch.hour     <= e.hour;
        req_ch.minute   <= e.minute;
        req_ch.entry_id <= e.id;
        req_ch.entry_on <= e.on;
        do
            @(posedge clk);
        while (!req_ch.ready);
        schedule_sb.take_request(act, e);
        beats_sent++;
    endtask

    task automatic directed_beats();
        // Empty table, then two entries on one minute and one on the next
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_APPEND, make_entry(3'd0, 5'd0, 6'd2, 8'hFF, 1'b1));
        send_beat(wtss_pkg::ACT_APPEND, make_entry(3'd0, 5'd0, 6'd2, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_APPEND, make_entry(3'd0, 5'd0, 6'd3, 8'h81, 1'b1));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        // Week wrap from Sunday 23:59 into Monday 00:00
        send_beat(wtss_pkg::ACT_SET,    make_entry(3'd6, 5'd23, 6'd59, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_APPEND, make_entry(3'd0, 5'd0, 6'd0, 8'h5A, 1'b1));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        // Out-of-range clock: minute 63 wraps without carry, entry matches
        send_beat(wtss_pkg::ACT_SET,    make_entry(3'd7, 5'd31, 6'd63, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_APPEND, make_entry(3'd7, 5'd31, 6'd0, 8'hA5, 1'b0));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        // Hour 31 carries to 0 without a day carry
        send_beat(wtss_pkg::ACT_SET,    make_entry(3'd5, 5'd31, 6'd59, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        // Out-of-range weekday goes to Monday on a day carry
        send_beat(wtss_pkg::ACT_SET,    make_entry(3'd7, 5'd23, 6'd59, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        // Clear drops every entry
        send_beat(wtss_pkg::ACT_CLEAR,  make_entry(3'd7, 5'd31, 6'd63, 8'hFF, 1'b1));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_APPEND, make_entry(3'd4, 5'd12, 6'd30, 8'h3C, 1'b1));
        send_beat(wtss_pkg::ACT_SET,    make_entry(3'd4, 5'd12, 6'd29, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_TICK,   make_entry(3'd0, 5'd0, 6'd0, 8'h00, 1'b0));
    endtask

    // Program entries on the next few minutes, set the clock, then tick through them
    task automatic scheduled_burst();
        clock_t           start;
        clock_t           slot [5];
        wtss_pkg::entry_t e;
        int               ticks;
        int               n_ent;
        e            = rand_entry();
        start.day    = e.day;
        start.hour   = e.hour;
        start.minute = e.minute;
        if ($urandom_range(0, 2) == 0)
        begin
            start.minute = 6'(57 + $urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1)
                start.hour = 5'd23;
            if ($urandom_range(0, 1) == 1)
                start.day = 3'd6;
        end
        ticks   = $urandom_range(1, 4);
        slot[0] = start;
        for (int k = 1; k <= ticks; k++)
            slot[k] = switch_scoreboard::next_minute(slot[k-1]);
        if ($urandom_range(0, 99) < 40)
            send_beat(wtss_pkg::ACT_CLEAR, rand_entry());
        n_ent = $urandom_range(0, 10);
        for (int k = 0; k < n_ent; k++)
        begin
            e = rand_entry();
            if ($urandom_range(0, 99) < 75)
            begin
                start    = slot[$urandom_range(1, ticks)];
                e.day    = start.day;
                e.hour   = start.hour;
                e.minute = start.minute;
            end
            send_beat(wtss_pkg::ACT_APPEND, e);
        end
        send_beat(wtss_pkg::ACT_SET, make_entry(slot[0].day, slot[0].hour, slot[0].minute,
                                                8'($urandom_range(0, 255)),
                                                1'($urandom_range(0, 1))));
        repeat (ticks)
            send_beat(wtss_pkg::ACT_TICK, rand_entry());
    endtask

    // Fill the table past its end with many entries on one minute
    task automatic fill_table();
        clock_t           at;
        clock_t           after;
        wtss_pkg::entry_t e;
        int               pick;
        at.day    = 3'($urandom_range(0, 6));
        at.hour   = 5'($urandom_range(0, 23));
        at.minute = 6'($urandom_range(1, 59));
        after     = switch_scoreboard::next_minute(at);
        send_beat(wtss_pkg::ACT_CLEAR, rand_entry());
        for (int k = 0; k < MAX_ENTRIES + 3; k++)
        begin
            e    = rand_entry();
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                e.day    = at.day;
                e.hour   = at.hour;
                e.minute = at.minute;
            end
            else if (pick < 8)
            begin
                e.day    = after.day;
                e.hour   = after.hour;
                e.minute = after.minute;
            end
            send_beat(wtss_pkg::ACT_APPEND, e);
        end
        send_beat(wtss_pkg::ACT_SET,
                  make_entry(at.day, at.hour, at.minute - 1'b1, 8'h00, 1'b0));
        send_beat(wtss_pkg::ACT_TICK, rand_entry());
        send_beat(wtss_pkg::ACT_TICK, rand_entry());
    endtask

    initial
    begin : stimulus
        int unsigned phase_end;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = wtss_pkg::ACT_TICK;
        req_ch.weekday  = '0;
        req_ch.hour     = '0;
        req_ch.minute   = '0;
        req_ch.entry_id = '0;
        req_ch.entry_on = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_beats();

        // Random part, one idling pattern per phase
        for (int p = 0; p < 4; p++)
        begin
            phase_end     = beats_sent + PHASE_BEATS;
            send_idle_pct = IDLE_PCT[p];
            stall_pct     = STALL_PCT[p];
            if (p == 2)
                hold_go = 1'b1;
            if (p == 3)
                fill_table();
            while (beats_sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 75)
                    scheduled_burst();
                else
                    repeat ($urandom_range(1, 3))
                        send_beat(wtss_pkg::action_t'($urandom_range(0, 3)), rand_entry());
            end
        end
        req_ch.valid <= 1'b0;

        // Drain, then watch for stray beats
        while (schedule_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (schedule_sb.error_count == 0 && schedule_sb.pending() == 0)
            $display("weekly_time_switch_scheduler_top_test: done, clean");
        else
            $display("weekly_time_switch_scheduler_top_test: done, errors");
        $finish;
    end

endmodule
